@@ hdl/tcm_pkg.sv @@
// Shared types, register codes and constant tables of the thermistor channel monitor.
// Depends on nothing; tcm_ctrl, tcm_dp and the top level import it.
`default_nettype none

package tcm_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_SEAT_LOW_FAULT      = 3'd0;
    localparam logic [2:0] CFG_SEAT_HIGH_FAULT     = 3'd1;
    localparam logic [2:0] CFG_FAN_LOW_FAULT       = 3'd2;
    localparam logic [2:0] CFG_FAN_HIGH_FAULT      = 3'd3;
    localparam logic [2:0] CFG_SEAT_OVERHEAT_LIMIT = 3'd4;
    localparam logic [2:0] CFG_FAN_OVERHEAT_LIMIT  = 3'd5;

    localparam logic [9:0] RST_SEAT_LOW_FAULT      = 10'd30;
    localparam logic [9:0] RST_SEAT_HIGH_FAULT     = 10'd994;
    localparam logic [9:0] RST_FAN_LOW_FAULT       = 10'd10;
    localparam logic [9:0] RST_FAN_HIGH_FAULT      = 10'd1000;
    localparam logic [6:0] RST_SEAT_OVERHEAT_LIMIT = 7'd55;
    localparam logic [6:0] RST_FAN_OVERHEAT_LIMIT  = 7'd65;

    localparam logic       SENSOR_SEAT = 1'b0;
    localparam logic       SENSOR_FAN  = 1'b1;

    localparam int         WIN_DEPTH  = 5;
    localparam logic [2:0] WIN_LAST   = 3'd4;
    localparam logic [6:0] SEAT_LAST  = 7'd70;
    localparam logic [6:0] FAN_LAST   = 7'd75;
    localparam int         TAB_DEPTH  = 76;

    // x / 3 as (x * 2731) >> 13, exact for x below 3072
    localparam logic [11:0] DIV3_RECIP = 12'd2731;
    localparam int          DIV3_SHIFT = 13;

    // internal fault nibble, sits at bits 7..4 of fault_flags
    localparam int FLT_SEAT_FAULT = 3;
    localparam int FLT_SEAT_OVH   = 2;
    localparam int FLT_FAN_FAULT  = 1;
    localparam int FLT_FAN_OVH    = 0;

    // seat table padded past its last index; the search never reads the padding
    localparam logic [9:0] SEAT_TAB [TAB_DEPTH] = '{
        10'd745, 10'd736, 10'd727, 10'd718, 10'd709, 10'd700, 10'd691, 10'd682,
        10'd672, 10'd663, 10'd653, 10'd644, 10'd634, 10'd625, 10'd615, 10'd605,
        10'd595, 10'd586, 10'd576, 10'd566, 10'd557, 10'd547, 10'd538, 10'd528,
        10'd518, 10'd509, 10'd499, 10'd490, 10'd480, 10'd471, 10'd461, 10'd452,
        10'd443, 10'd434, 10'd425, 10'd416, 10'd407, 10'd398, 10'd390, 10'd381,
        10'd373, 10'd365, 10'd356, 10'd348, 10'd341, 10'd333, 10'd325, 10'd318,
        10'd311, 10'd303, 10'd296, 10'd289, 10'd283, 10'd276, 10'd269, 10'd263,
        10'd257, 10'd251, 10'd245, 10'd239, 10'd233, 10'd227, 10'd222, 10'd216,
        10'd211, 10'd206, 10'd201, 10'd196, 10'd191, 10'd187, 10'd182, 10'd182,
        10'd182, 10'd182, 10'd182, 10'd182
    };

    localparam logic [9:0] FAN_TAB [TAB_DEPTH] = '{
        10'd745, 10'd342, 10'd332, 10'd323, 10'd314, 10'd305, 10'd296, 10'd287,
        10'd279, 10'd271, 10'd263, 10'd255, 10'd248, 10'd240, 10'd233, 10'd226,
        10'd219, 10'd212, 10'd206, 10'd200, 10'd194, 10'd188, 10'd182, 10'd177,
        10'd171, 10'd166, 10'd161, 10'd156, 10'd151, 10'd146, 10'd142, 10'd137,
        10'd133, 10'd129, 10'd125, 10'd121, 10'd117, 10'd113, 10'd110, 10'd106,
        10'd103, 10'd100, 10'd97,  10'd94,  10'd91,  10'd88,  10'd85,  10'd83,
        10'd80,  10'd78,  10'd75,  10'd73,  10'd71,  10'd69,  10'd67,  10'd65,
        10'd63,  10'd61,  10'd59,  10'd57,  10'd56,  10'd54,  10'd52,  10'd51,
        10'd49,  10'd48,  10'd46,  10'd45,  10'd44,  10'd43,  10'd41,  10'd40,
        10'd39,  10'd38,  10'd37,  10'd36
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_CHECK,
        ST_SEARCH,
        ST_FINISH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic div_mul;
        logic check;
        logic search_step;
        logic finish;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic scan_last;
        logic fault_now;
        logic search_done;
        logic out_free;
    } t_status;

    function automatic logic [5:0] heater_setpoint(input logic [6:0] amb);
        logic [5:0] sp;
        priority if (amb < 7'd10) sp = 6'd36;
        else if (amb < 7'd15) sp = 6'd34;
        else if (amb < 7'd20) sp = 6'd32;
        else if (amb < 7'd25) sp = 6'd30;
        else sp = 6'd25;
        return sp;
    endfunction

endpackage

`default_nettype wire

@@ hdl/tcm_if.sv @@
// Channel interfaces of the thermistor channel monitor: sample in, result out, config write.
// Stand-alone; no package needed.
`default_nettype none

interface tcm_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] sample;
    logic       sensor_select;
    logic [6:0] ambient_degrees;
    logic       power_on;
    logic       test_mode;

    modport source (output valid, sample, sensor_select, ambient_degrees, power_on,
                    test_mode, input ready);
    modport sink   (input valid, sample, sensor_select, ambient_degrees, power_on,
                    test_mode, output ready);
endinterface

interface tcm_out_if;
    logic       valid;
    logic       ready;
    logic       sensor_id;
    logic [9:0] filtered_value;
    logic [6:0] degrees;
    logic [7:0] fault_flags;
    logic       heater_on;

    modport source (output valid, sensor_id, filtered_value, degrees, fault_flags,
                    heater_on, input ready);
    modport sink   (input valid, sensor_id, filtered_value, degrees, fault_flags,
                    heater_on, output ready);
endinterface

interface tcm_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] reg_index;
    logic [9:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

@@ hdl/tcm_ctrl.sv @@
// Sequencer of the thermistor channel monitor: steps an item that completes its window
// through scan, divide, range check, table search, flag update and emit. Uses tcm_pkg.
`default_nettype none

module tcm_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  tcm_pkg::t_status   i_status,
    output logic               o_in_ready,
    output tcm_pkg::t_cmd      o_cmd,
    output tcm_pkg::t_state    o_state
);
    import tcm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.full) n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_mul = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                // a reading out of range keeps degrees and overheat as they were
                n_state = i_status.fault_now ? ST_FINISH : ST_SEARCH;
            end
            ST_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_status.search_done) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

@@ hdl/tcm_dp.sv @@
// Datapath of the thermistor channel monitor: sample windows, trimmed mean, table search,
// fault and heater flags, config registers and the result register. Uses tcm_pkg.
`default_nettype none

module tcm_dp (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  tcm_pkg::t_cmd  i_cmd,
    output tcm_pkg::t_status o_status,
    // input item payload
    input  wire  [9:0]     i_sample,
    input  wire            i_sensor_select,
    input  wire  [6:0]     i_ambient_degrees,
    input  wire            i_power_on,
    input  wire            i_test_mode,
    // config write
    input  wire            i_cfg_valid,
    input  wire  [2:0]     i_cfg_index,
    input  wire  [9:0]     i_cfg_data,
    // result register
    input  wire            i_out_ready,
    output logic           o_out_valid,
    output logic           o_sensor_id,
    output logic [9:0]     o_filtered_value,
    output logic [6:0]     o_degrees,
    output logic [7:0]     o_fault_flags,
    output logic           o_heater_on
);
    import tcm_pkg::*;

    // config
    logic [9:0]  r_seat_low, r_seat_high, r_fan_low, r_fan_high;
    logic [6:0]  r_seat_ovh, r_fan_ovh;

    // windows and fill counts
    logic [9:0]  r_win [2][WIN_DEPTH];
    logic [2:0]  r_fill [2];

    // item context
    logic        r_sel;
    logic [6:0]  r_amb;
    logic        r_pwr;
    logic        r_tst;

    // working registers
    logic [6:0]  r_idx;
    logic [12:0] r_sum;
    logic [9:0]  r_max, r_min;
    logic [23:0] r_prod;
    logic [9:0]  r_mean;

    // persistent results
    logic [3:0]  r_fault;
    logic [6:0]  r_deg [2];
    logic        r_heater;

    logic        r_out_valid;
    logic        r_out_sel;
    logic [9:0]  r_out_mean;
    logic [6:0]  r_out_deg;
    logic [7:0]  r_out_flags;
    logic        r_out_heater;

    logic [9:0]  w_cur;
    logic [11:0] w_trim;
    logic [9:0]  w_mean;
    logic        w_fault;
    logic [9:0]  w_tab;
    logic [6:0]  w_last;
    logic        w_more;
    logic [6:0]  w_limit;

    assign w_cur   = r_win[r_sel][r_idx[2:0]];
    assign w_trim  = 12'(r_sum - 13'(r_max) - 13'(r_min));
    assign w_mean  = r_prod[DIV3_SHIFT +: 10];
    assign w_fault = r_sel ? ((w_mean < r_fan_low) || (w_mean > r_fan_high))
                           : ((w_mean < r_seat_low) || (w_mean > r_seat_high));
    assign w_tab   = r_sel ? FAN_TAB[r_idx] : SEAT_TAB[r_idx];
    assign w_last  = r_sel ? FAN_LAST : SEAT_LAST;
    assign w_more  = (r_idx < w_last) && (r_mean < w_tab);
    assign w_limit = r_sel ? r_fan_ovh : r_seat_ovh;

    assign o_status.full        = (r_fill[i_sensor_select] == WIN_LAST);
    assign o_status.scan_last   = (r_idx[2:0] == WIN_LAST);
    assign o_status.fault_now   = w_fault;
    assign o_status.search_done = !w_more;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seat_low  <= RST_SEAT_LOW_FAULT;
            r_seat_high <= RST_SEAT_HIGH_FAULT;
            r_fan_low   <= RST_FAN_LOW_FAULT;
            r_fan_high  <= RST_FAN_HIGH_FAULT;
            r_seat_ovh  <= RST_SEAT_OVERHEAT_LIMIT;
            r_fan_ovh   <= RST_FAN_OVERHEAT_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SEAT_LOW_FAULT:      r_seat_low  <= i_cfg_data;
                CFG_SEAT_HIGH_FAULT:     r_seat_high <= i_cfg_data;
                CFG_FAN_LOW_FAULT:       r_fan_low   <= i_cfg_data;
                CFG_FAN_HIGH_FAULT:      r_fan_high  <= i_cfg_data;
                CFG_SEAT_OVERHEAT_LIMIT: r_seat_ovh  <= i_cfg_data[6:0];
                CFG_FAN_OVERHEAT_LIMIT:  r_fan_ovh   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // window store, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_win[i_sensor_select][r_fill[i_sensor_select]] <= i_sample;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sel <= i_sensor_select;
            r_amb <= i_ambient_degrees;
            r_pwr <= i_power_on;
            r_tst <= i_test_mode;
        end
        if (i_cmd.scan_step) begin
            if (r_idx[2:0] == 3'd0) begin
                r_sum <= 13'(w_cur);
                r_max <= w_cur;
                r_min <= w_cur;
            end else begin
                r_sum <= r_sum + 13'(w_cur);
                if (w_cur > r_max) r_max <= w_cur;
                if (w_cur < r_min) r_min <= w_cur;
            end
        end
        if (i_cmd.div_mul) begin
            r_prod <= w_trim * DIV3_RECIP;
        end
        if (i_cmd.check) begin
            r_mean <= w_mean;
        end
        if (i_cmd.emit) begin
            r_out_sel    <= r_sel;
            r_out_mean   <= r_mean;
            r_out_deg    <= r_deg[r_sel];
            r_out_flags  <= {r_fault, 4'b0000};
            r_out_heater <= r_heater;
        end
    end

    // control state: fills, index, flags, degrees, heater, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill[0]   <= '0;
            r_fill[1]   <= '0;
            r_idx       <= '0;
            r_fault     <= '0;
            r_deg[0]    <= '0;
            r_deg[1]    <= '0;
            r_heater    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_idx <= '0;
                if (r_fill[i_sensor_select] == WIN_LAST) begin
                    r_fill[i_sensor_select] <= '0;
                end else begin
                    r_fill[i_sensor_select] <= r_fill[i_sensor_select] + 3'd1;
                end
            end
            if (i_cmd.scan_step) begin
                r_idx <= r_idx + 7'd1;
            end
            if (i_cmd.check) begin
                r_idx <= '0;
                if (r_sel == SENSOR_FAN) r_fault[FLT_FAN_FAULT]  <= w_fault;
                else                     r_fault[FLT_SEAT_FAULT] <= w_fault;
            end
            if (i_cmd.search_step) begin
                if (w_more) begin
                    r_idx <= r_idx + 7'd1;
                end else begin
                    r_deg[r_sel] <= r_idx;
                    if (r_sel == SENSOR_FAN) r_fault[FLT_FAN_OVH]  <= (r_idx >= w_limit);
                    else                     r_fault[FLT_SEAT_OVH] <= (r_idx >= w_limit);
                end
            end
            // heater follows only completed seat windows with power on, no test, no fault
            if (i_cmd.finish && (r_sel == SENSOR_SEAT) && !r_tst && r_pwr && (r_fault == 4'd0)) begin
                r_heater <= (r_deg[0] <= {1'b0, heater_setpoint(r_amb)});
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sensor_id      = r_out_sel;
    assign o_filtered_value = r_out_mean;
    assign o_degrees        = r_out_deg;
    assign o_fault_flags    = r_out_flags;
    assign o_heater_on      = r_out_heater;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill[0] <= WIN_LAST) && (r_fill[1] <= WIN_LAST))
        else $error("window fill count beyond last slot");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.search_step |-> (r_idx <= w_last))
        else $error("table search ran past the last index");

    a_heater_seat_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_heater) |-> $past(i_cmd.finish && (r_sel == SENSOR_SEAT)))
        else $error("heater changed outside a seat window update");

endmodule

`default_nettype wire

@@ hdl/thermistor_channel_monitor_top.sv @@
// Top level of the thermistor channel monitor: joins the sequencer and the datapath to
// the sample, result and config channels. Uses tcm_pkg, tcm_if, tcm_ctrl and tcm_dp.
//
//  channel   port       dir   payload
//  -------   ---------  ----  -----------------------------------------------------------
//  samples   i_in_ch    in    sample, sensor_select, ambient_degrees, power_on, test_mode
//  results   o_res_ch   out   sensor_id, filtered_value, degrees, fault_flags, heater_on
//  config    i_cfg_ch   in    reg_index, wr_data (always ready)
//
// A sample that leaves its window short is taken in the idle state alone. A sample that
// completes a window passes through its accept, the scan of its window, a multiply, a
// range check, a linear table search (one entry per cycle, none for a reading out of
// range), a heater update and an emit step that waits while the last result is not taken.
// A result waits in its output register; the next sample is taken once it is loaded.
// Reset is synchronous: fill counts, degrees, fault flags and heater clear, limits reload.
`default_nettype none

module thermistor_channel_monitor_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tcm_in_if.sink     i_in_ch,
    tcm_out_if.source  o_res_ch,
    tcm_cfg_if.sink    i_cfg_ch
);
    import tcm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    t_state  w_state;
    logic    w_in_ready;

    tcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    tcm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_sample          (i_in_ch.sample),
        .i_sensor_select   (i_in_ch.sensor_select),
        .i_ambient_degrees (i_in_ch.ambient_degrees),
        .i_power_on        (i_in_ch.power_on),
        .i_test_mode       (i_in_ch.test_mode),
        .i_cfg_valid       (i_cfg_ch.valid),
        .i_cfg_index       (i_cfg_ch.reg_index),
        .i_cfg_data        (i_cfg_ch.wr_data),
        .i_out_ready       (o_res_ch.ready),
        .o_out_valid       (o_res_ch.valid),
        .o_sensor_id       (o_res_ch.sensor_id),
        .o_filtered_value  (o_res_ch.filtered_value),
        .o_degrees         (o_res_ch.degrees),
        .o_fault_flags     (o_res_ch.fault_flags),
        .o_heater_on       (o_res_ch.heater_on)
    );

    assign i_in_ch.ready  = w_in_ready;
    assign i_cfg_ch.ready = 1'b1;

    a_rise_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_ch.valid) |-> $past(w_state == ST_EMIT))
        else $error("result valid rose without an emit step");

    a_emit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> (w_state == ST_IDLE) && o_res_ch.valid)
        else $error("emit did not load the result and return to idle");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ST_SEARCH) |-> !(i_in_ch.valid && i_in_ch.ready))
        else $error("sample taken during table search");

endmodule

`default_nettype wire
